FILE: rtl/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and helpers for the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] RANK_LOW  = 2'd0;
   localparam logic [1:0] RANK_ADD  = 2'd1;
   localparam logic [1:0] RANK_MUL  = 2'd2;

   typedef enum logic [2:0] {
      K_SPACE,
      K_DIGIT,
      K_OPEN,
      K_CLOSE,
      K_OPER
   } sym_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROC,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } stack_op_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one;
      logic two;
   } stack_stat_type;

   function automatic logic [1:0] rank_of(input logic [7:0] c);
      logic [1:0] r;
      r = RANK_LOW;
      if (c inside {CHAR_PLUS, CHAR_MINUS}) begin
         r = RANK_ADD;
      end else if (c inside {CHAR_STAR, CHAR_SLASH}) begin
         r = RANK_MUL;
      end
      return r;
   endfunction

   function automatic sym_kind_type kind_of(input logic [7:0] c);
      sym_kind_type k;
      k = K_OPER;
      if (c == CHAR_SPACE) begin
         k = K_SPACE;
      end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         k = K_DIGIT;
      end else if (c == CHAR_OPEN) begin
         k = K_OPEN;
      end else if (c == CHAR_CLOSE) begin
         k = K_CLOSE;
      end
      return k;
   endfunction

endpackage

FILE: rtl/itp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_req_if
// Input channel: one expression character and its end-of-expression mark.
// ----------------------------------------------------------------------------
interface itp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_expression;

   modport source (output valid, output symbol, output end_of_expression, input ready);
   modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

FILE: rtl/itp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_rsp_if
// Result channel: one postfix character with end and overflow flags.
// ----------------------------------------------------------------------------
interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_symbol;
   logic       symbol_valid;
   logic       last;
   logic       overflow;

   modport source (output valid, output out_symbol, output symbol_valid,
                   output last, output overflow, input ready);
   modport sink   (input valid, input out_symbol, input symbol_valid,
                   input last, input overflow, output ready);
endinterface

FILE: rtl/infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
// Timing: each accepted character is registered, then each result is registered in the output register.
// Throughput: a new character is taken only in the idle state, once the last one and its pops are done;
//   an end-of-expression character also waits until the stack is flushed or the bare end marker is sent.
// The single operator stack, one push or pop a cycle, sets the pace; a stalled result holds it.
// Reset: synchronous, active high; empties the stack and clears the overflow flag and output.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard infix to postfix converter, one character per transaction.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   itp_req_if.sink   req,
   itp_rsp_if.source rsp
);

   stack_op_type   stack_op;
   stack_stat_type stack_stat;
   logic [7:0]     stack_top;
   logic [7:0]     stack_below;

   itp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .op    (stack_op),
      .stat  (stack_stat),
      .top   (stack_top),
      .below (stack_below)
   );

   itp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .op    (stack_op),
      .stat  (stack_stat),
      .top   (stack_top),
      .below (stack_below)
   );

endmodule

FILE: rtl/itp_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack in a memory with registered reads of the top two entries.
// ----------------------------------------------------------------------------
module itp_stack
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  stack_op_type   op,
   output stack_stat_type stat,
   output logic [7:0]     top,
   output logic [7:0]     below
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    mem [STACK_DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] rd_idx;
   logic [CW-1:0] rd2_idx;
   logic [7:0]    top_ff;
   logic [7:0]    below_ff;
   logic          do_push;
   logic          do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(STACK_DEPTH));
   assign stat.one   = (count_ff == CW'(1));
   assign stat.two   = (count_ff == CW'(2));
   assign top        = top_ff;
   assign below      = below_ff;

   assign do_push = op.push && !stat.full;
   assign do_pop  = op.pop && !stat.empty;

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CW'(1);
      end
      rd_idx  = count_in - CW'(1);
      rd2_idx = count_in - CW'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // top_ff and below_ff hold the two entries at the next count; a push forwards its data
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[count_ff[AW-1:0]] <= op.data;
         top_ff                <= op.data;
         below_ff              <= top_ff;
      end else begin
         if (count_in != '0) begin
            top_ff <= mem[rd_idx[AW-1:0]];
         end
         if (count_in > CW'(1)) begin
            below_ff <= mem[rd2_idx[AW-1:0]];
         end
      end
   end

endmodule

FILE: rtl/itp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer for the shunting-yard steps and the result output register.
// ----------------------------------------------------------------------------
module itp_ctrl
   import itp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   itp_req_if.sink        req,
   itp_rsp_if.source      rsp,
   output stack_op_type   op,
   input  stack_stat_type stat,
   input  logic [7:0]     top,
   input  logic [7:0]     below
);

   ctrl_state_type state_ff, state_in;
   logic [7:0]     sym_ff, sym_in;
   logic           eoe_ff, eoe_in;
   logic           ovf_ff, ovf_in;
   logic           emitted_ff, emitted_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_sym_ff, rsp_sym_in;
   logic           rsp_sv_ff, rsp_sv_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic           out_free;
   logic           emit;
   logic [7:0]     e_sym;
   logic           e_sv;
   logic           e_last;
   sym_kind_type   kind;
   ctrl_state_type after_state;

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_symbol   = rsp_sym_ff;
   assign rsp.symbol_valid = rsp_sv_ff;
   assign rsp.last         = rsp_last_ff;
   assign rsp.overflow     = rsp_ovf_ff;

   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign kind        = kind_of(sym_ff);
   assign after_state = eoe_ff ? ST_FLUSH : ST_IDLE;

   always_comb begin
      state_in   = state_ff;
      sym_in     = sym_ff;
      eoe_in     = eoe_ff;
      ovf_in     = ovf_ff;
      emitted_in = emitted_ff;
      emit       = 1'b0;
      e_sym      = top;
      e_sv       = 1'b1;
      e_last     = 1'b0;
      op.push    = 1'b0;
      op.pop     = 1'b0;
      op.data    = sym_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               sym_in     = req.symbol;
               eoe_in     = req.end_of_expression;
               emitted_in = 1'b0;
               state_in   = ST_PROC;
            end
         end
         ST_PROC: begin
            case (kind)
               K_SPACE: begin
                  state_in = after_state;
               end
               K_DIGIT: begin
                  if (out_free) begin
                     emit       = 1'b1;
                     e_sym      = sym_ff;
                     e_last     = eoe_ff && stat.empty;
                     emitted_in = 1'b1;
                     state_in   = after_state;
                  end
               end
               K_OPEN: begin
                  op.push = 1'b1;
                  if (stat.full) begin
                     ovf_in = 1'b1;
                  end
                  state_in = after_state;
               end
               K_CLOSE: begin
                  if (!stat.empty && top != CHAR_OPEN) begin
                     if (out_free) begin
                        emit       = 1'b1;
                        // also last when only an open paren remains to be dropped
                        e_last     = eoe_ff && (stat.one || (stat.two && below == CHAR_OPEN));
                        emitted_in = 1'b1;
                        op.pop     = 1'b1;
                     end
                  end else begin
                     // matching open paren is dropped
                     op.pop   = !stat.empty;
                     state_in = after_state;
                  end
               end
               K_OPER: begin
                  if (!stat.empty && rank_of(top) >= rank_of(sym_ff)) begin
                     if (out_free) begin
                        emit       = 1'b1;
                        emitted_in = 1'b1;
                        op.pop     = 1'b1;
                     end
                  end else begin
                     op.push = 1'b1;
                     if (stat.full) begin
                        ovf_in = 1'b1;
                     end
                     state_in = after_state;
                  end
               end
               default: begin
                  state_in = after_state;
               end
            endcase
         end
         ST_FLUSH: begin
            if (!stat.empty) begin
               if (out_free) begin
                  emit       = 1'b1;
                  e_last     = stat.one;
                  emitted_in = 1'b1;
                  op.pop     = 1'b1;
                  if (stat.one) begin
                     ovf_in   = 1'b0;
                     state_in = ST_IDLE;
                  end
               end
            end else if (!emitted_ff) begin
               // bare end marker when the end-of-expression character produced nothing
               if (out_free) begin
                  emit     = 1'b1;
                  e_sym    = '0;
                  e_sv     = 1'b0;
                  e_last   = 1'b1;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end else begin
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = e_sym;
         rsp_sv_in    = e_sv;
         rsp_last_in  = e_last;
         rsp_ovf_in   = ovf_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ovf_ff       <= 1'b0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ovf_ff       <= ovf_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      eoe_ff      <= eoe_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_sv_ff   <= rsp_sv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

endmodule

FILE: sim/infix_to_postfix_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb
// Sends infix expression characters into the converter and checks the stream
// of postfix results against a shunting-yard predictor kept in the bench.
// Directed expressions come first, then random expressions, deep nests that
// can overflow the operator stack, and noise. Both channels idle and stall at
// random, and one long result stall backs the block up into its input.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top_tb;
   import itp_pkg::*;

   localparam int STACK_DEPTH   = DEFAULT_STACK_DEPTH;
   localparam int TARGET_CHARS  = 210;
   localparam int MAX_GAP       = 14;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [7:0] symbol;
      logic       eoe;
      int         gap;
   } char_item_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       symbol_valid;
      logic       last;
      logic       overflow;
   } postfix_sym_type;

   logic clock;
   logic reset;

   itp_req_if req_chan ();
   itp_rsp_if rsp_chan ();

   infix_to_postfix_converter_top #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   char_item_type   pending_chars[$];
   postfix_sym_type expected_postfix[$];

   // predictor state
   logic [7:0] op_stack [STACK_DEPTH];
   int         op_depth = 0;
   logic       dropped_push = 1'b0;

   int   chars_accepted = 0;
   int   mismatches = 0;
   int   cycle_count = 0;
   int   gap_left = 0;
   int   stall_left = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic burst_mode = 1'b0;
   logic steady_sink = 1'b0;
   logic sink_hold = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [1:0] precedence(input logic [7:0] c);
      case (c)
         CHAR_PLUS, CHAR_MINUS: return RANK_ADD;
         CHAR_STAR, CHAR_SLASH: return RANK_MUL;
         default:               return RANK_LOW;
      endcase
   endfunction

   function automatic void push_operator(input logic [7:0] c);
      if (op_depth >= STACK_DEPTH) begin
         dropped_push = 1'b1;
      end else begin
         op_stack[op_depth] = c;
         op_depth++;
      end
   endfunction

   function automatic void shunt_symbol(input logic [7:0] c, input logic eoe);
      postfix_sym_type step[$];
      postfix_sym_type item;
      logic [1:0]      rank;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         step.push_back('{c, 1'b1, 1'b0, 1'b0});
      end else if (c == CHAR_OPEN) begin
         push_operator(c);
      end else if (c == CHAR_CLOSE) begin
         while (op_depth > 0 && op_stack[op_depth - 1] != CHAR_OPEN) begin
            op_depth--;
            step.push_back('{op_stack[op_depth], 1'b1, 1'b0, 1'b0});
         end
         // matching open paren is discarded
         if (op_depth > 0) begin
            op_depth--;
         end
      end else if (c != CHAR_SPACE) begin
         rank = precedence(c);
         while (op_depth > 0 && precedence(op_stack[op_depth - 1]) >= rank) begin
            op_depth--;
            step.push_back('{op_stack[op_depth], 1'b1, 1'b0, 1'b0});
         end
         push_operator(c);
      end
      if (eoe) begin
         while (op_depth > 0) begin
            op_depth--;
            step.push_back('{op_stack[op_depth], 1'b1, 1'b0, 1'b0});
         end
         // bare end marker when nothing else comes out
         if (step.size() == 0) begin
            step.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
         end
         item = step.pop_back();
         item.last = 1'b1;
         step.push_back(item);
      end
      foreach (step[i]) begin
         item = step[i];
         item.overflow = dropped_push;
         expected_postfix.push_back(item);
      end
      if (eoe) begin
         dropped_push = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic add_char(input logic [7:0] s, input logic e);
      char_item_type ci;
      ci.symbol = s;
      ci.eoe    = e;
      ci.gap    = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      pending_chars.push_back(ci);
   endtask

   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 9))
         0, 1:    return CHAR_PLUS;
         2, 3:    return CHAR_MINUS;
         4, 5:    return CHAR_STAR;
         6, 7:    return CHAR_SLASH;
         8:       return 8'h5E;
         default: return 8'h25;
      endcase
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic end_expression();
      char_item_type ci;
      ci = pending_chars.pop_back();
      ci.eoe = 1'b1;
      pending_chars.push_back(ci);
   endtask

   task automatic add_expression();
      int n_terms;
      int depth;
      n_terms = $urandom_range(1, 6);
      depth   = 0;
      for (int t = 0; t < n_terms; t++) begin
         if (t > 0) begin
            add_char(random_operator(), 1'b0);
         end
         while (depth < 4 && $urandom_range(0, 3) == 0) begin
            add_char(CHAR_OPEN, 1'b0);
            depth++;
         end
         if ($urandom_range(0, 5) == 0) begin
            add_char(CHAR_SPACE, 1'b0);
         end
         add_char(random_digit(), 1'b0);
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            add_char(CHAR_CLOSE, 1'b0);
            depth--;
         end
      end
      // unmatched opens are sometimes left for the flush
      while (depth > 0 && $urandom_range(0, 4) != 0) begin
         add_char(CHAR_CLOSE, 1'b0);
         depth--;
      end
      end_expression();
   endtask

   task automatic add_deep_nest();
      int n_open;
      n_open = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 3);
      for (int i = 0; i < n_open; i++) begin
         add_char(CHAR_OPEN, 1'b0);
      end
      add_char(random_digit(), 1'b0);
      for (int i = $urandom_range(0, 3); i > 0; i--) begin
         add_char(random_operator(), 1'b0);
         add_char(random_digit(), 1'b0);
      end
      for (int i = $urandom_range(0, n_open); i > 0; i--) begin
         add_char(CHAR_CLOSE, 1'b0);
      end
      end_expression();
   endtask

   task automatic add_noise();
      for (int i = $urandom_range(1, 6); i > 0; i--) begin
         add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic add_directed();
      // lone space at end: bare marker
      add_char(CHAR_SPACE, 1'b1);
      // all four operators with mixed precedence, digit extremes
      add_char(CHAR_ZERO, 1'b0);
      add_char(CHAR_PLUS, 1'b0);
      add_char(CHAR_NINE, 1'b0);
      add_char(CHAR_STAR, 1'b0);
      add_char(8'h37, 1'b0);
      add_char(CHAR_MINUS, 1'b0);
      add_char(8'h38, 1'b0);
      add_char(CHAR_SLASH, 1'b0);
      add_char(8'h32, 1'b1);
      // parenthesized group
      add_char(CHAR_OPEN, 1'b0);
      add_char(8'h31, 1'b0);
      add_char(CHAR_PLUS, 1'b0);
      add_char(8'h32, 1'b0);
      add_char(CHAR_CLOSE, 1'b0);
      add_char(CHAR_STAR, 1'b0);
      add_char(8'h33, 1'b1);
      // unmatched close
      add_char(8'h35, 1'b0);
      add_char(CHAR_PLUS, 1'b0);
      add_char(CHAR_CLOSE, 1'b1);
      // unmatched open left for the flush
      add_char(CHAR_OPEN, 1'b0);
      add_char(8'h34, 1'b1);
      // unknown codes rank lowest and pop a stacked open paren
      add_char(8'h78, 1'b0);
      add_char(CHAR_OPEN, 1'b0);
      add_char(8'h00, 1'b0);
      add_char(8'hFF, 1'b1);
      // closing paren ends the expression with an operator above the open paren
      add_char(CHAR_OPEN, 1'b0);
      add_char(8'h31, 1'b0);
      add_char(CHAR_PLUS, 1'b0);
      add_char(8'h32, 1'b0);
      add_char(CHAR_CLOSE, 1'b1);
   endtask

   // ---------------------------------------------------------------- channels

   // character driver
   always @(negedge clock) begin : char_driver
      logic offer;
      offer = req_chan.valid;
      if (reset) begin
         offer    = 1'b0;
         gap_left = 0;
      end else begin
         if (req_taken) begin
            offer = 1'b0;
         end
         if (!offer && pending_chars.size() > 0) begin
            if (gap_left < pending_chars[0].gap) begin
               gap_left++;
            end else begin
               req_chan.symbol            <= pending_chars[0].symbol;
               req_chan.end_of_expression <= pending_chars[0].eoe;
               void'(pending_chars.pop_front());
               offer    = 1'b1;
               gap_left = 0;
            end
         end
      end
      req_chan.valid <= offer;
   end

   // result ready with per-transaction stalls
   always @(negedge clock) begin : result_sink
      logic take;
      take = 1'b0;
      if (!reset) begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) begin
               steady_sink = !steady_sink;
            end
            stall_left = steady_sink ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall_left > 0) begin
            stall_left--;
         end else begin
            take = !sink_hold;
         end
      end
      rsp_chan.ready <= take;
   end

   // one long stall on the result side while characters keep coming
   initial begin : long_hold
      wait (chars_accepted >= 70);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      sink_hold = 1'b0;
   end

   task automatic note_mismatch(input string what, input postfix_sym_type want,
                                input postfix_sym_type seen);
      if (mismatches < REPORT_LIMIT) begin
         $display("%0t mismatch (%s): expected sym=%02h valid=%0b last=%0b ovf=%0b,",
                  $realtime, what, want.out_symbol, want.symbol_valid, want.last,
                  want.overflow,
                  " got sym=%02h valid=%0b last=%0b ovf=%0b",
                  seen.out_symbol, seen.symbol_valid, seen.last, seen.overflow);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      postfix_sym_type seen;
      postfix_sym_type want;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         req_taken = req_chan.valid && req_chan.ready;
         rsp_taken = rsp_chan.valid && rsp_chan.ready;
         if (req_taken) begin
            shunt_symbol(req_chan.symbol, req_chan.end_of_expression);
            chars_accepted++;
         end
         if (rsp_taken) begin
            seen = '{rsp_chan.out_symbol, rsp_chan.symbol_valid, rsp_chan.last,
                     rsp_chan.overflow};
            if (expected_postfix.size() == 0) begin
               note_mismatch("unexpected transaction", '0, seen);
            end else begin
               want = expected_postfix.pop_front();
               if (seen !== want) begin
                  note_mismatch("wrong field", want, seen);
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin : main_seq
      int pick;
      reset                      = 1'b1;
      req_chan.valid             = 1'b0;
      req_chan.symbol            = 8'h00;
      req_chan.end_of_expression = 1'b0;
      rsp_chan.ready             = 1'b0;

      add_directed();
      while (pending_chars.size() < TARGET_CHARS) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            add_deep_nest();
         end else if (pick <= 2) begin
            add_noise();
         end else begin
            add_expression();
         end
      end
      end_expression();

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      wait (pending_chars.size() == 0);
      @(posedge clock);
      while (req_chan.valid) @(posedge clock);
      while (expected_postfix.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
